/* rtl/microwire_serial_eeprom_unit_assert.svh */
// Assertion macros for the serial EEPROM unit
`ifndef MICROWIRE_SERIAL_EEPROM_UNIT_ASSERT_SVH
`define MICROWIRE_SERIAL_EEPROM_UNIT_ASSERT_SVH

`ifndef NO_ASSERTIONS

// same-cycle implication
`define MWE_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("assertion failed: same-cycle implication");

// next-cycle implication
`define MWE_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("assertion failed: next-cycle implication");

`else

`define MWE_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define MWE_ASSERT_NXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

/* rtl/mwe_pkg.sv */
package mwe_pkg;

	localparam int ADDRESS_BITS_DEF = 8;
	localparam int WORD_BITS_DEF    = 16;

	// busy counter holds write_busy_ticks or the WRAL word count
	localparam int BUSY_W  = 17;
	localparam int TICKS_W = 16;
	localparam int APB_DW  = 32;
	localparam int APB_AW  = 3;

	// register index, taken from paddr[2]
	localparam logic REG_WRITE_BUSY_TICKS = 1'b0;

	localparam logic [1:0] OP_EXT   = 2'b00;
	localparam logic [1:0] OP_WRITE = 2'b01;
	localparam logic [1:0] OP_READ  = 2'b10;

	// sub-codes of OP_EXT: top two address bits
	localparam logic [1:0] SUB_EWDS = 2'b00;
	localparam logic [1:0] SUB_WRAL = 2'b01;
	localparam logic [1:0] SUB_EWEN = 2'b11;

	typedef enum logic [2:0] {
		PH_IDLE,
		PH_CMD,
		PH_DATA,
		PH_READ,
		PH_DONE
	} phase_t;

endpackage

/* rtl/mwe_ram.sv */
module mwe_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// read data holds until the next read
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

/* rtl/microwire_serial_eeprom_unit.sv */
// Device side of a three-wire serial EEPROM (93C66 style, x16). Each start
// transfer is one rising edge of the serial clock carrying chip_select and
// data_in; the block takes one per clock cycle, every cycle, and busy stays
// low. The result for a transfer (data_out, busy_res) appears on the cycle
// after start, marked by done, for that one cycle only; the receiver cannot
// stall it. The words live in one 2^ADDRESS_BITS x WORD_BITS RAM with a
// registered read: a READ issues the RAM read on the tick that completes the
// address, and the next tick shifts from the RAM output. WRAL programs one
// word per tick until all 2^ADDRESS_BITS words are written, reported on busy_res.
`include "microwire_serial_eeprom_unit_assert.svh"

module microwire_serial_eeprom_unit #(
	parameter int ADDRESS_BITS = mwe_pkg::ADDRESS_BITS_DEF,
	parameter int WORD_BITS    = mwe_pkg::WORD_BITS_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	output logic                      busy,
	input  logic                      chip_select,
	input  logic                      data_in,
	output logic                      done,
	output logic                      data_out,
	output logic                      busy_res,
	input  logic                      psel,
	input  logic                      penable,
	input  logic                      pwrite,
	input  logic [mwe_pkg::APB_AW-1:0] paddr,
	input  logic [mwe_pkg::APB_DW-1:0] pwdata,
	output logic [mwe_pkg::APB_DW-1:0] prdata,
	output logic                      pready
);

	localparam int WORDS    = 1 << ADDRESS_BITS;
	localparam int CMD_BITS = ADDRESS_BITS + 2;
	localparam int MAX_BITS = (CMD_BITS > WORD_BITS) ? CMD_BITS : WORD_BITS;
	localparam int CNT_W    = $clog2(MAX_BITS + 1);
	localparam int BW       = mwe_pkg::BUSY_W;

	mwe_pkg::phase_t phase_q, phase_d;

	logic                    wen_q, wen_d;
	logic [WORD_BITS-1:0]    shift_q, shift_d, sw_cur;
	logic [CMD_BITS-1:0]     oa_q, oa_d, oa_n;
	logic [CNT_W-1:0]        cnt_q, cnt_d, cnt_inc;
	logic [BW-1:0]           bcnt_q, bcnt_d, bc, neg_bc;
	logic                    load_q, load_d;
	logic [mwe_pkg::TICKS_W-1:0] ticks_q;
	logic                    done_q, dout_q, bres_q;
	logic                    dout;
	logic                    acc, cfg_wr;
	logic [WORD_BITS-1:0]    sh_n;
	logic [1:0]              op_n, sub_n;

	logic                    ram_we, ram_re;
	logic [ADDRESS_BITS-1:0] ram_waddr, ram_raddr;
	logic [WORD_BITS-1:0]    ram_wdata, ram_rdata;

	assign busy   = 1'b0;
	assign acc    = start & ~busy;
	assign pready = 1'b1;
	assign cfg_wr = psel & penable & pwrite & pready;
	assign prdata = (paddr[2] == mwe_pkg::REG_WRITE_BUSY_TICKS) ?
		mwe_pkg::APB_DW'(ticks_q) : '0;

	assign done     = done_q;
	assign data_out = dout_q;
	assign busy_res = bres_q;

	mwe_ram #(
		.WIDTH(WORD_BITS),
		.DEPTH(WORDS)
	) u_store (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (ram_re),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	// a READ's word sits in the RAM output until the next transfer takes it
	assign sw_cur = load_q ? ram_rdata : shift_q;
	assign neg_bc = BW'(0) - bcnt_q;
	assign oa_n   = {oa_q[CMD_BITS-2:0], data_in};
	assign op_n   = oa_n[CMD_BITS-1 -: 2];
	assign sub_n  = oa_n[ADDRESS_BITS-1 -: 2];
	assign sh_n   = {sw_cur[WORD_BITS-2:0], data_in};

	always_comb begin
		phase_d   = phase_q;
		wen_d     = wen_q;
		shift_d   = sw_cur;
		oa_d      = oa_q;
		cnt_d     = cnt_q;
		cnt_inc   = cnt_q + CNT_W'(1);
		load_d    = 1'b0;
		dout      = 1'b0;
		ram_we    = 1'b0;
		ram_waddr = neg_bc[ADDRESS_BITS-1:0];
		ram_wdata = sw_cur;
		ram_re    = 1'b0;
		ram_raddr = oa_n[ADDRESS_BITS-1:0];
		bc        = bcnt_q;

		// programming advances before the serial bit is handled
		if (bcnt_q != '0) begin
			if (oa_q[CMD_BITS-1 -: 2] == mwe_pkg::OP_EXT &&
			    oa_q[ADDRESS_BITS-1 -: 2] == mwe_pkg::SUB_WRAL) begin
				ram_we = acc;
			end
			bc = bcnt_q - BW'(1);
		end
		bcnt_d = bc;

		if (!chip_select) begin
			phase_d = mwe_pkg::PH_IDLE;
		end else begin
			unique case (phase_q)
				mwe_pkg::PH_IDLE: begin
					if (data_in && bc == '0) begin
						phase_d = mwe_pkg::PH_CMD;
						oa_d    = '0;
						cnt_d   = '0;
					end else begin
						dout = (bc == '0);
					end
				end
				mwe_pkg::PH_CMD: begin
					oa_d  = oa_n;
					cnt_d = cnt_inc;
					if (cnt_inc >= CNT_W'(CMD_BITS)) begin
						cnt_d = '0;
						if (op_n == mwe_pkg::OP_READ) begin
							ram_re  = acc;
							load_d  = 1'b1;
							phase_d = mwe_pkg::PH_READ;
						end else if (op_n == mwe_pkg::OP_WRITE ||
						             (op_n == mwe_pkg::OP_EXT &&
						              sub_n == mwe_pkg::SUB_WRAL)) begin
							shift_d = '0;
							phase_d = mwe_pkg::PH_DATA;
						end else begin
							if (op_n == mwe_pkg::OP_EXT && sub_n == mwe_pkg::SUB_EWEN) begin
								wen_d = 1'b1;
							end else if (op_n == mwe_pkg::OP_EXT &&
							             sub_n == mwe_pkg::SUB_EWDS) begin
								wen_d = 1'b0;
							end
							phase_d = mwe_pkg::PH_DONE;
						end
					end
				end
				mwe_pkg::PH_DATA: begin
					shift_d = sh_n;
					cnt_d   = cnt_inc;
					if (cnt_inc >= CNT_W'(WORD_BITS)) begin
						cnt_d   = '0;
						phase_d = mwe_pkg::PH_DONE;
						if (wen_q) begin
							if (oa_q[CMD_BITS-1 -: 2] == mwe_pkg::OP_WRITE) begin
								ram_we    = acc;
								ram_waddr = oa_q[ADDRESS_BITS-1:0];
								ram_wdata = sh_n;
								bcnt_d    = BW'(ticks_q);
							end else begin
								bcnt_d = BW'(WORDS);
							end
						end
					end
				end
				mwe_pkg::PH_READ: begin
					dout    = sw_cur[WORD_BITS-1];
					shift_d = {sw_cur[WORD_BITS-2:0], 1'b0};
					cnt_d   = cnt_inc;
					if (cnt_inc >= CNT_W'(WORD_BITS)) begin
						cnt_d   = '0;
						phase_d = mwe_pkg::PH_DONE;
					end
				end
				mwe_pkg::PH_DONE: begin
					dout = (bc == '0);
				end
				default: begin
					phase_d = mwe_pkg::PH_DONE;
					dout    = (bc == '0);
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= mwe_pkg::PH_IDLE;
			wen_q   <= 1'b0;
			shift_q <= '0;
			oa_q    <= '0;
			cnt_q   <= '0;
			bcnt_q  <= '0;
			load_q  <= 1'b0;
			done_q  <= 1'b0;
			dout_q  <= 1'b0;
			bres_q  <= 1'b0;
		end else begin
			done_q <= acc;
			if (acc) begin
				phase_q <= phase_d;
				wen_q   <= wen_d;
				shift_q <= shift_d;
				oa_q    <= oa_d;
				cnt_q   <= cnt_d;
				bcnt_q  <= bcnt_d;
				load_q  <= load_d;
				dout_q  <= dout;
				bres_q  <= (bcnt_d != '0);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ticks_q <= '0;
		end else if (cfg_wr && paddr[2] == mwe_pkg::REG_WRITE_BUSY_TICKS) begin
			ticks_q <= pwdata[mwe_pkg::TICKS_W-1:0];
		end
	end

	`MWE_ASSERT_NXT(a_done_follows, clk, arst_n, acc, done)
	`MWE_ASSERT_NXT(a_no_stray_done, clk, arst_n, !acc, !done)
	`MWE_ASSERT_IMP(a_quiet_when_busy, clk, arst_n, done && busy_res, !data_out)

endmodule
